### src/weighted_ik_qp_setup_assert.svh
// Assertion helpers shared by the checker; clk and rst_n must be in scope.
`ifndef WEIGHTED_IK_QP_SETUP_ASSERT_SVH
`define WEIGHTED_IK_QP_SETUP_ASSERT_SVH

// cond implies prop in the same cycle
`define WIQ_ASSERT_SAME(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("weighted_ik_qp_setup: same-cycle check failed");

// cond implies prop in the following cycle
`define WIQ_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("weighted_ik_qp_setup: next-cycle check failed");

`endif

### src/wiq_pkg.sv
package wiq_pkg;

    localparam int MAX_JOINTS = 7;
    localparam int NUM_TWIST  = 6;

    typedef enum logic [2:0] {
        CFG_POS_WEIGHT = 3'd0,
        CFG_ORI_WEIGHT = 3'd1,
        CFG_REGULARIZE = 3'd2,
        CFG_NOM_WEIGHT = 3'd3,
        CFG_NOM_GAIN   = 3'd4,
        CFG_VEL_SCALE  = 3'd5,
        CFG_LIM_MARGIN = 3'd6,
        CFG_INV_DT     = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] jac_lin_x;
        logic signed [31:0] jac_lin_y;
        logic signed [31:0] jac_lin_z;
        logic signed [31:0] jac_ang_x;
        logic signed [31:0] jac_ang_y;
        logic signed [31:0] jac_ang_z;
        logic signed [31:0] joint_pos;
        logic signed [31:0] pos_lower;
        logic signed [31:0] pos_upper;
        logic        [30:0] vel_limit;
        logic signed [31:0] twist_elem;
    } in_item_t;

    typedef struct packed {
        logic        [2:0]  row_index;
        logic signed [31:0] hess_c0;
        logic signed [31:0] hess_c1;
        logic signed [31:0] hess_c2;
        logic signed [31:0] hess_c3;
        logic signed [31:0] hess_c4;
        logic signed [31:0] hess_c5;
        logic signed [31:0] hess_c6;
        logic signed [31:0] gradient;
        logic signed [31:0] vel_lower_bound;
        logic signed [31:0] vel_upper_bound;
        logic               last_row;
    } out_item_t;

    typedef struct packed {
        logic cap_a;
        logic use_tw;
    } lane_ctl_t;

    typedef struct packed {
        logic signed [31:0] w2_pos;
        logic signed [31:0] w2_ori;
        logic signed [47:0] nwq;
        logic signed [47:0] vel;
        logic signed [47:0] pl;
        logic signed [47:0] pu;
    } scal_res_t;

    // Q16.16 round: add half an LSB, floor shift by 16
    function automatic logic signed [47:0] qround(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p + 64'sd32768;
        return s[63:16];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [55:0] x);
        if (x > 56'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -56'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

endpackage

### src/wiq_ram.sv
module wiq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 7,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

### src/wiq_lane.sv
module wiq_lane #(
    parameter int NUM_JOINTS = 7,
    localparam int AW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  logic [31:0]         wdata,
    input  logic                tw_we,
    input  logic [31:0]         tw_data,
    input  logic [AW-1:0]       raddr,
    input  wiq_pkg::lane_ctl_t  ctl,
    input  logic signed [31:0]  w2,
    output logic signed [47:0]  term
);
    import wiq_pkg::*;

    logic [31:0]        rdata;
    logic signed [31:0] a_reg;
    logic signed [31:0] tw_reg;
    logic signed [31:0] b_sel;
    logic signed [63:0] p1_reg;
    logic signed [31:0] t_reg;
    logic signed [63:0] p2_reg;
    logic signed [47:0] term_reg;

    wiq_ram #(.WIDTH(32), .DEPTH(NUM_JOINTS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign b_sel = ctl.use_tw ? tw_reg : signed'(rdata);

    // column element times row element, round, clamp, then weight
    always_ff @(posedge clk)
    begin
        if (tw_we)
            tw_reg <= signed'(tw_data);
        if (ctl.cap_a)
            a_reg <= signed'(rdata);
        p1_reg   <= a_reg * b_sel;
        t_reg    <= sat32(56'(qround(p1_reg)));
        p2_reg   <= t_reg * w2;
        term_reg <= qround(p2_reg);
    end

    assign term = term_reg;

endmodule

### src/wiq_merge.sv
module wiq_merge (
    input  logic               clk,
    input  logic signed [47:0] terms [wiq_pkg::NUM_TWIST],
    input  logic signed [51:0] addend,
    output logic signed [51:0] sum
);
    import wiq_pkg::*;

    logic signed [51:0] pa_reg;
    logic signed [51:0] pb_reg;
    logic signed [51:0] sum_reg;

    always_ff @(posedge clk)
    begin
        pa_reg  <= 52'(terms[0]) + 52'(terms[1]) + 52'(terms[2]);
        pb_reg  <= 52'(terms[3]) + 52'(terms[4]) + 52'(terms[5]) + addend;
        sum_reg <= pa_reg + pb_reg;
    end

    assign sum = sum_reg;

endmodule

### src/wiq_scalar.sv
module wiq_scalar (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [30:0]         pos_weight,
    input  logic [30:0]         ori_weight,
    input  logic [30:0]         nom_weight,
    input  logic [30:0]         nom_gain,
    input  logic [30:0]         vel_scale,
    input  logic [30:0]         margin,
    input  logic [30:0]         inv_dt,
    input  logic signed [31:0]  pos,
    input  logic signed [31:0]  lower,
    input  logic signed [31:0]  upper,
    input  logic [30:0]         vel_limit,
    output logic                done,
    output wiq_pkg::scal_res_t  res
);
    import wiq_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_RND} state_t;
    typedef enum logic [2:0] {
        OP_WP, OP_WO, OP_QDN, OP_NWQ, OP_VEL, OP_PL, OP_PU
    } op_t;

    state_t             state_reg;
    op_t                op_reg;
    logic               done_reg;
    scal_res_t          res_reg;
    logic signed [31:0] qdn_reg;
    logic signed [63:0] mul_reg;

    logic signed [32:0] sum33;
    logic signed [31:0] mid;
    logic signed [33:0] off34;
    logic signed [33:0] sl34;
    logic signed [33:0] su34;
    logic signed [31:0] a_sel;
    logic signed [31:0] b_sel;
    logic signed [47:0] rnd;

    always_comb
    begin
        sum33 = 33'(lower) + 33'(upper);
        mid   = sum33[32:1];
        off34 = 34'(pos) - 34'(mid);
        sl34  = 34'(lower) + signed'({3'b000, margin}) - 34'(pos);
        su34  = 34'(upper) - signed'({3'b000, margin}) - 34'(pos);
        case (op_reg)
            OP_WP:
            begin
                a_sel = signed'({1'b0, pos_weight});
                b_sel = signed'({1'b0, pos_weight});
            end
            OP_WO:
            begin
                a_sel = signed'({1'b0, ori_weight});
                b_sel = signed'({1'b0, ori_weight});
            end
            OP_QDN:
            begin
                a_sel = signed'({1'b0, nom_gain});
                b_sel = sat32(56'(off34));
            end
            OP_NWQ:
            begin
                a_sel = signed'({1'b0, nom_weight});
                b_sel = qdn_reg;
            end
            OP_VEL:
            begin
                a_sel = signed'({1'b0, vel_scale});
                b_sel = signed'({1'b0, vel_limit});
            end
            OP_PL:
            begin
                a_sel = sat32(56'(sl34));
                b_sel = signed'({1'b0, inv_dt});
            end
            OP_PU:
            begin
                a_sel = sat32(56'(su34));
                b_sel = signed'({1'b0, inv_dt});
            end
            default:
            begin
                a_sel = '0;
                b_sel = '0;
            end
        endcase
        rnd = qround(mul_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_WP;
            done_reg  <= 1'b0;
            res_reg   <= '0;
            qdn_reg   <= '0;
            mul_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= OP_WP;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    mul_reg   <= a_sel * b_sel;
                    state_reg <= S_RND;
                end
                S_RND:
                begin
                    case (op_reg)
                        OP_WP:   res_reg.w2_pos <= sat32(56'(rnd));
                        OP_WO:   res_reg.w2_ori <= sat32(56'(rnd));
                        OP_QDN:  qdn_reg        <= sat32(-56'(rnd));
                        OP_NWQ:  res_reg.nwq    <= rnd;
                        OP_VEL:  res_reg.vel    <= rnd;
                        OP_PL:   res_reg.pl     <= rnd;
                        OP_PU:   res_reg.pu     <= rnd;
                        default: res_reg.pu     <= rnd;
                    endcase
                    if (op_reg == OP_PU)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        op_reg    <= op_t'(op_reg + 3'd1);
                        state_reg <= S_MUL;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

### src/weighted_ik_qp_setup.sv
// Channel  | Direction | Handshake            | Payload
// in       | in        | in_valid / in_ready  | in_data   (one joint per request)
// out      | out       | out_valid / out_ready| out_data  (one QP row per request)
// cfg      | in        | cfg_en               | cfg_index, cfg_data
//
// Loading accepts one joint request per cycle; after the last joint the block emits
// NUM_JOINTS rows, each in turn: seven passes of the shared scalar multiplier,
// NUM_JOINTS + 2 issues into the six row lanes, the lane and merge pipeline,
// a state to format the row and one to hand it over.
// in_ready is high only while loading.
// rst_n clears control and restores the register defaults; stores hold no reset.
// A stalled row holds in the output register until out_ready.
module weighted_ik_qp_setup #(
    parameter int NUM_JOINTS = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  wiq_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output wiq_pkg::out_item_t  out_data,
    input  logic                cfg_en,
    input  logic [2:0]          cfg_index,
    input  logic [30:0]         cfg_data
);
    import wiq_pkg::*;

    localparam int AW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int PIPE = 7;

    typedef enum logic [2:0] {
        ST_LOAD, ST_SCAL, ST_ISSUE, ST_DRAIN, ST_FIN, ST_OUT
    } state_t;
    typedef enum logic [1:0] {K_LOADA, K_HESS, K_GRAD} kind_t;
    typedef struct packed {
        logic       vld;
        kind_t      kind;
        logic [2:0] col;
    } tag_t;

    state_t    state_reg;
    logic [2:0] load_cnt_reg;
    logic [2:0] row_reg;
    logic [3:0] iss_reg;
    logic       start_reg;
    tag_t      tg_reg [PIPE];
    out_item_t out_reg;

    logic [30:0] pos_w_reg, ori_w_reg, reg_reg, nom_w_reg;
    logic [30:0] gain_reg, vscale_reg, margin_reg, inv_dt_reg;

    logic signed [31:0] pos_st [NUM_JOINTS];
    logic signed [31:0] lo_st  [NUM_JOINTS];
    logic signed [31:0] up_st  [NUM_JOINTS];
    logic        [30:0] vel_st [NUM_JOINTS];
    logic signed [31:0] hess_reg [MAX_JOINTS];
    logic signed [51:0] gsum_reg;

    logic               in_acc;
    logic               out_acc;
    logic [31:0]        jac_in [NUM_TWIST];
    logic signed [47:0] terms  [NUM_TWIST];
    logic signed [51:0] sum;
    logic signed [51:0] addend;
    logic [AW-1:0]      raddr;
    logic [3:0]         iss_m1;
    lane_ctl_t          lane_ctl;
    tag_t               iss_tag;
    logic               scal_done;
    scal_res_t          scal_res;
    logic [31:0]        diag;
    logic signed [47:0] neg_vel;
    logic signed [47:0] lo_b;
    logic signed [47:0] hi_b;
    logic signed [31:0] hess_out [MAX_JOINTS];

    assign in_acc   = in_valid && in_ready;
    assign out_acc  = out_valid && out_ready;
    assign in_ready = (state_reg == ST_LOAD);
    assign out_valid = (state_reg == ST_OUT);
    assign out_data  = out_reg;

    assign jac_in[0] = in_data.jac_lin_x;
    assign jac_in[1] = in_data.jac_lin_y;
    assign jac_in[2] = in_data.jac_lin_z;
    assign jac_in[3] = in_data.jac_ang_x;
    assign jac_in[4] = in_data.jac_ang_y;
    assign jac_in[5] = in_data.jac_ang_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_w_reg  <= 31'd65536;
            ori_w_reg  <= 31'd65536;
            reg_reg    <= 31'd66;
            nom_w_reg  <= 31'd0;
            gain_reg   <= 31'd0;
            vscale_reg <= 31'd65536;
            margin_reg <= 31'd0;
            inv_dt_reg <= 31'd6553600;
        end
        else if (cfg_en)
        begin
            case (cfg_index)
                CFG_POS_WEIGHT: pos_w_reg  <= cfg_data;
                CFG_ORI_WEIGHT: ori_w_reg  <= cfg_data;
                CFG_REGULARIZE: reg_reg    <= cfg_data;
                CFG_NOM_WEIGHT: nom_w_reg  <= cfg_data;
                CFG_NOM_GAIN:   gain_reg   <= cfg_data;
                CFG_VEL_SCALE:  vscale_reg <= cfg_data;
                CFG_LIM_MARGIN: margin_reg <= cfg_data;
                CFG_INV_DT:     inv_dt_reg <= cfg_data;
                default:        inv_dt_reg <= inv_dt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            pos_st[load_cnt_reg[AW-1:0]] <= in_data.joint_pos;
            lo_st[load_cnt_reg[AW-1:0]]  <= in_data.pos_lower;
            up_st[load_cnt_reg[AW-1:0]]  <= in_data.pos_upper;
            vel_st[load_cnt_reg[AW-1:0]] <= in_data.vel_limit;
        end
    end

    // issue order per row: column operand, Hessian columns, gradient
    always_comb
    begin
        iss_m1 = iss_reg - 4'd1;
        if (iss_reg == 4'd0)
        begin
            raddr   = row_reg[AW-1:0];
            iss_tag = '{vld: 1'b1, kind: K_LOADA, col: 3'd0};
        end
        else if (iss_reg <= 4'(NUM_JOINTS))
        begin
            raddr   = iss_m1[AW-1:0];
            iss_tag = '{vld: 1'b1, kind: K_HESS, col: iss_m1[2:0]};
        end
        else
        begin
            raddr   = '0;
            iss_tag = '{vld: 1'b1, kind: K_GRAD, col: 3'd0};
        end
        if (state_reg != ST_ISSUE)
            iss_tag.vld = 1'b0;
    end

    assign lane_ctl.cap_a  = tg_reg[0].vld && (tg_reg[0].kind == K_LOADA);
    assign lane_ctl.use_tw = tg_reg[0].vld && (tg_reg[0].kind == K_GRAD);

    assign diag   = 32'(reg_reg) + 32'(nom_w_reg);
    assign addend = (tg_reg[4].vld && tg_reg[4].kind == K_HESS && tg_reg[4].col == row_reg)
                    ? 52'(signed'({1'b0, diag})) : '0;

    genvar r;
    generate
        for (r = 0; r < NUM_TWIST; r++)
        begin : g_lane
            wiq_lane #(.NUM_JOINTS(NUM_JOINTS)) u_lane (
                .clk     (clk),
                .we      (in_acc),
                .waddr   (load_cnt_reg[AW-1:0]),
                .wdata   (jac_in[r]),
                .tw_we   (in_acc && (load_cnt_reg == 3'(r))),
                .tw_data (in_data.twist_elem),
                .raddr   (raddr),
                .ctl     (lane_ctl),
                .w2      ((r < 3) ? scal_res.w2_pos : scal_res.w2_ori),
                .term    (terms[r])
            );
        end
    endgenerate

    wiq_merge u_merge (
        .clk    (clk),
        .terms  (terms),
        .addend (addend),
        .sum    (sum)
    );

    wiq_scalar u_scalar (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start_reg),
        .pos_weight (pos_w_reg),
        .ori_weight (ori_w_reg),
        .nom_weight (nom_w_reg),
        .nom_gain   (gain_reg),
        .vel_scale  (vscale_reg),
        .margin     (margin_reg),
        .inv_dt     (inv_dt_reg),
        .pos        (pos_st[row_reg[AW-1:0]]),
        .lower      (lo_st[row_reg[AW-1:0]]),
        .upper      (up_st[row_reg[AW-1:0]]),
        .vel_limit  (vel_st[row_reg[AW-1:0]]),
        .done       (scal_done),
        .res        (scal_res)
    );

    always_ff @(posedge clk)
    begin
        if (tg_reg[PIPE-1].vld && tg_reg[PIPE-1].kind == K_HESS)
            hess_reg[tg_reg[PIPE-1].col] <= sat32(56'(sum));
        if (tg_reg[PIPE-1].vld && tg_reg[PIPE-1].kind == K_GRAD)
            gsum_reg <= sum;
    end

    always_comb
    begin
        neg_vel = -scal_res.vel;
        lo_b = (neg_vel > scal_res.pl) ? neg_vel : scal_res.pl;
        hi_b = (scal_res.vel < scal_res.pu) ? scal_res.vel : scal_res.pu;
        for (int j = 0; j < MAX_JOINTS; j++)
            hess_out[j] = (j < NUM_JOINTS) ? hess_reg[j] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            load_cnt_reg <= '0;
            row_reg      <= '0;
            iss_reg      <= '0;
            start_reg    <= 1'b0;
            out_reg      <= '0;
            for (int k = 0; k < PIPE; k++)
                tg_reg[k] <= '0;
        end
        else
        begin
            start_reg <= 1'b0;
            tg_reg[0] <= iss_tag;
            for (int k = 1; k < PIPE; k++)
                tg_reg[k] <= tg_reg[k-1];
            case (state_reg)
                ST_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (load_cnt_reg == 3'(NUM_JOINTS - 1))
                        begin
                            load_cnt_reg <= '0;
                            row_reg      <= '0;
                            start_reg    <= 1'b1;
                            state_reg    <= ST_SCAL;
                        end
                        else
                            load_cnt_reg <= load_cnt_reg + 3'd1;
                    end
                end
                ST_SCAL:
                begin
                    if (scal_done)
                    begin
                        iss_reg   <= '0;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE:
                begin
                    iss_reg <= iss_reg + 4'd1;
                    if (iss_reg == 4'(NUM_JOINTS + 1))
                        state_reg <= ST_DRAIN;
                end
                ST_DRAIN:
                begin
                    if (tg_reg[PIPE-1].vld && tg_reg[PIPE-1].kind == K_GRAD)
                        state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    out_reg.row_index       <= row_reg;
                    out_reg.hess_c0         <= hess_out[0];
                    out_reg.hess_c1         <= hess_out[1];
                    out_reg.hess_c2         <= hess_out[2];
                    out_reg.hess_c3         <= hess_out[3];
                    out_reg.hess_c4         <= hess_out[4];
                    out_reg.hess_c5         <= hess_out[5];
                    out_reg.hess_c6         <= hess_out[6];
                    out_reg.gradient        <= sat32(-56'(gsum_reg) - 56'(scal_res.nwq));
                    out_reg.vel_lower_bound <= sat32(56'(lo_b));
                    out_reg.vel_upper_bound <= sat32(56'(hi_b));
                    out_reg.last_row        <= (row_reg == 3'(NUM_JOINTS - 1));
                    state_reg               <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_acc)
                    begin
                        if (row_reg == 3'(NUM_JOINTS - 1))
                            state_reg <= ST_LOAD;
                        else
                        begin
                            row_reg   <= row_reg + 3'd1;
                            start_reg <= 1'b1;
                            state_reg <= ST_SCAL;
                        end
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

endmodule

### src/wiq_checker.sv
module wiq_checker #(
    parameter int NUM_JOINTS = 7
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input wiq_pkg::out_item_t out_data
);
    `include "weighted_ik_qp_setup_assert.svh"

    localparam logic [2:0] LAST_ROW = 3'(NUM_JOINTS - 1);

    // a row never shows while joints are still being taken
    `WIQ_ASSERT_SAME(a_no_overlap, out_valid, !in_ready)
    // the final row carries the last joint index
    `WIQ_ASSERT_SAME(a_last_index, out_valid && out_data.last_row, out_data.row_index == LAST_ROW)
    // after the final row the block returns to loading
    `WIQ_ASSERT_NEXT(a_back_to_load, out_valid && out_ready && out_data.last_row, in_ready)
    // a stalled row holds
    `WIQ_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind weighted_ik_qp_setup wiq_checker #(.NUM_JOINTS(NUM_JOINTS)) u_wiq_checker (.*);

### tb/sv/wiq_checker.sv
module wiq_scoreboard #(
    parameter int NUM_JOINTS = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  wiq_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  wiq_pkg::out_item_t out_data,
    input  logic               cfg_en,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    output int                 fail_count,
    output int                 rows_pending
);
    import wiq_pkg::*;

    longint cfg_reg [8];
    longint jac [6][MAX_JOINTS];
    longint jpos [MAX_JOINTS];
    longint plo [MAX_JOINTS];
    longint phi [MAX_JOINTS];
    longint vlim [MAX_JOINTS];
    longint twist [NUM_TWIST];
    int     joint_cnt;
    out_item_t row_queue [$];

    assign rows_pending = row_queue.size();

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    // floor shift: >>> on a signed longint rounds toward minus infinity
    function automatic longint qmul(longint a, longint b);
        return (a * b + 64'sd32768) >>> 16;
    endfunction

    function automatic logic [31:0] pack32(longint x);
        longint s;
        s = clamp32(x);
        return s[31:0];
    endfunction

    task automatic build_rows();
        longint w2 [6];
        longint wp, wo, h, g, t, mid, offs, qdn, vel, pl, pu, lo, hi;
        logic [31:0] hrow [MAX_JOINTS];
        out_item_t row;
        wp = clamp32(qmul(cfg_reg[CFG_POS_WEIGHT], cfg_reg[CFG_POS_WEIGHT]));
        wo = clamp32(qmul(cfg_reg[CFG_ORI_WEIGHT], cfg_reg[CFG_ORI_WEIGHT]));
        for (int r = 0; r < 6; r++)
            w2[r] = (r < 3) ? wp : wo;
        for (int i = 0; i < NUM_JOINTS; i++)
        begin
            for (int j = 0; j < MAX_JOINTS; j++)
            begin
                h = 0;
                if (j < NUM_JOINTS)
                begin
                    for (int r = 0; r < 6; r++)
                    begin
                        t = clamp32(qmul(jac[r][i], jac[r][j]));
                        h += qmul(t, w2[r]);
                    end
                    if (j == i)
                        h += cfg_reg[CFG_REGULARIZE] + cfg_reg[CFG_NOM_WEIGHT];
                end
                hrow[j] = pack32(h);
            end
            g = 0;
            for (int r = 0; r < 6; r++)
            begin
                t = clamp32(qmul(jac[r][i], twist[r]));
                g -= qmul(t, w2[r]);
            end
            mid  = (plo[i] + phi[i]) >>> 1;
            offs = clamp32(jpos[i] - mid);
            qdn  = clamp32(-qmul(cfg_reg[CFG_NOM_GAIN], offs));
            g   -= qmul(cfg_reg[CFG_NOM_WEIGHT], qdn);
            vel = qmul(cfg_reg[CFG_VEL_SCALE], vlim[i]);
            pl  = qmul(clamp32(plo[i] + cfg_reg[CFG_LIM_MARGIN] - jpos[i]),
                       cfg_reg[CFG_INV_DT]);
            pu  = qmul(clamp32(phi[i] - cfg_reg[CFG_LIM_MARGIN] - jpos[i]),
                       cfg_reg[CFG_INV_DT]);
            lo = (-vel > pl) ? -vel : pl;
            hi = (vel < pu) ? vel : pu;
            row.row_index       = i[2:0];
            row.hess_c0         = hrow[0];
            row.hess_c1         = hrow[1];
            row.hess_c2         = hrow[2];
            row.hess_c3         = hrow[3];
            row.hess_c4         = hrow[4];
            row.hess_c5         = hrow[5];
            row.hess_c6         = hrow[6];
            row.gradient        = pack32(g);
            row.vel_lower_bound = pack32(lo);
            row.vel_upper_bound = pack32(hi);
            row.last_row        = (i == NUM_JOINTS - 1);
            row_queue.push_back(row);
        end
    endtask

    task automatic load_joint(in_item_t d);
        int k;
        k = (joint_cnt >= NUM_JOINTS) ? 0 : joint_cnt;
        jac[0][k] = longint'(d.jac_lin_x);
        jac[1][k] = longint'(d.jac_lin_y);
        jac[2][k] = longint'(d.jac_lin_z);
        jac[3][k] = longint'(d.jac_ang_x);
        jac[4][k] = longint'(d.jac_ang_y);
        jac[5][k] = longint'(d.jac_ang_z);
        jpos[k] = longint'(d.joint_pos);
        plo[k]  = longint'(d.pos_lower);
        phi[k]  = longint'(d.pos_upper);
        vlim[k] = longint'({1'b0, d.vel_limit});
        if (k < NUM_TWIST)
            twist[k] = longint'(d.twist_elem);
        if (k + 1 < NUM_JOINTS)
            joint_cnt = k + 1;
        else
        begin
            joint_cnt = 0;
            build_rows();
        end
    endtask

    task automatic check_field(string fname, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: mismatch on %s: expected %0d, actual %0d",
                     $time, fname, want, got);
            fail_count++;
        end
    endtask

    task automatic check_row(out_item_t got);
        out_item_t want;
        if (row_queue.size() == 0)
        begin
            $display("%0t: unexpected row: expected none, actual row %0d",
                     $time, got.row_index);
            fail_count++;
            return;
        end
        want = row_queue.pop_front();
        check_field("row_index", want.row_index, got.row_index);
        check_field("hess_c0", want.hess_c0, got.hess_c0);
        check_field("hess_c1", want.hess_c1, got.hess_c1);
        check_field("hess_c2", want.hess_c2, got.hess_c2);
        check_field("hess_c3", want.hess_c3, got.hess_c3);
        check_field("hess_c4", want.hess_c4, got.hess_c4);
        check_field("hess_c5", want.hess_c5, got.hess_c5);
        check_field("hess_c6", want.hess_c6, got.hess_c6);
        check_field("gradient", want.gradient, got.gradient);
        check_field("vel_lower_bound", want.vel_lower_bound, got.vel_lower_bound);
        check_field("vel_upper_bound", want.vel_upper_bound, got.vel_upper_bound);
        check_field("last_row", want.last_row, got.last_row);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[CFG_POS_WEIGHT] = 65536;
            cfg_reg[CFG_ORI_WEIGHT] = 65536;
            cfg_reg[CFG_REGULARIZE] = 66;
            cfg_reg[CFG_NOM_WEIGHT] = 0;
            cfg_reg[CFG_NOM_GAIN]   = 0;
            cfg_reg[CFG_VEL_SCALE]  = 65536;
            cfg_reg[CFG_LIM_MARGIN] = 0;
            cfg_reg[CFG_INV_DT]     = 6553600;
            joint_cnt = 0;
            row_queue.delete();
        end
        else
        begin
            if (cfg_en)
                cfg_reg[cfg_index] = longint'({33'd0, cfg_data});
            if (out_valid && out_ready)
                check_row(out_data);
            if (in_valid && in_ready)
                load_joint(in_data);
        end
    end

    initial fail_count = 0;
endmodule

### tb/sv/tb.sv
module tb;
    import wiq_pkg::*;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;
    logic cfg_en;
    logic [2:0] cfg_index;
    logic [30:0] cfg_data;
    int fail_count;
    int rows_pending;
    int idle_cycles;
    int cycle_cnt;
    int burst_left;

    localparam int WATCHDOG_LIMIT = 20000;

    weighted_ik_qp_setup DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    wiq_scoreboard u_scoreboard (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .rows_pending(rows_pending)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // receiver: random stalls, clear stretches, and one long hold-off
    always @(negedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= 1500 && cycle_cnt < 2100)
            out_ready <= 1'b0;
        else if ((cycle_cnt / 256) % 3 == 0)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("weighted_ik_qp_setup regression: fail");
            $finish;
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom();
            3: return 32'd0;
            default: return $urandom_range(0, 32'h3ffff) - 32'h20000;
        endcase
    endfunction

    function automatic in_item_t random_joint();
        in_item_t d;
        logic signed [31:0] a;
        d.jac_lin_x  = pick_value();
        d.jac_lin_y  = pick_value();
        d.jac_lin_z  = pick_value();
        d.jac_ang_x  = pick_value();
        d.jac_ang_y  = pick_value();
        d.jac_ang_z  = pick_value();
        d.twist_elem = pick_value();
        d.vel_limit  = 31'(($urandom_range(0, 7) == 0) ? $urandom()
                                                        : $urandom_range(0, 32'h40000));
        if ($urandom_range(0, 4) == 0)
        begin
            d.joint_pos = pick_value();
            d.pos_lower = pick_value();
            d.pos_upper = pick_value();
        end
        else
        begin
            a = $urandom_range(0, 32'h30000);
            d.pos_lower = -a;
            d.pos_upper = a + $urandom_range(0, 32'h10000);
            d.joint_pos = d.pos_lower + $urandom_range(0, 2 * a);
        end
        return d;
    endfunction

    task automatic send_joint(in_item_t d);
        if (burst_left == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        else
            @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= d;
        do
            @(posedge clk);
        while (!in_ready);
        burst_left--;
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [30:0] val);
        @(negedge clk);
        cfg_en    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_en <= 1'b0;
    endtask

    // drain, then let the pipeline settle before touching registers
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (rows_pending != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_all(logic [30:0] v [8]);
        for (int i = 0; i < 8; i++)
            write_reg(cfg_idx_t'(i), v[i]);
    endtask

    initial
    begin
        logic [30:0] regset [8];
        in_item_t d;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_en = 1'b0;
        cfg_index = CFG_POS_WEIGHT;
        cfg_data = '0;
        idle_cycles = 0;
        cycle_cnt = 0;
        burst_left = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, zeros, crossed limits, under reset defaults
        for (int k = 0; k < 7; k++)
        begin
            d = (k % 2 == 0) ? {32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                                32'h7fffffff, 31'h7fffffff, 32'h7fffffff}
                             : {32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                                32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                                32'h80000000, 31'h0, 32'h80000000};
            send_joint(d);
        end
        for (int k = 0; k < 7; k++)
        begin
            d = '0;
            if (k > 3)
            begin
                d.pos_lower = 32'h00020000;
                d.pos_upper = -32'sh00020000;
                d.jac_ang_z = 32'h00010000;
                d.vel_limit = 31'h00010000;
            end
            send_joint(d);
        end
        wait_idle();

        // register settings: max, zero (including zero reciprocal), unity with chosen overrides, then random
        for (int ph = 0; ph < 5; ph++)
        begin
            for (int i = 0; i < 8; i++)
                case (ph)
                    0: regset[i] = 31'h7fffffff;
                    1: regset[i] = 31'h0;
                    2: regset[i] = 31'h00010000;
                    default: regset[i] = 31'($urandom_range(0, 32'h30000));
                endcase
            if (ph == 2)
            begin
                regset[CFG_NOM_WEIGHT] = 31'h00008000;
                regset[CFG_NOM_GAIN]   = 31'h00020000;
                regset[CFG_LIM_MARGIN] = 31'h00001000;
                regset[CFG_INV_DT]     = 31'd1;
            end
            write_all(regset);
            for (int p = 0; p < ((ph < 2) ? 2 : 3); p++)
                for (int k = 0; k < 7; k++)
                    send_joint(random_joint());
            wait_idle();
        end

        if (fail_count == 0)
            $display("weighted_ik_qp_setup regression: pass");
        else
            $display("weighted_ik_qp_setup regression: fail");
        $finish;
    end
endmodule

### weighted_ik_qp_setup.f
+incdir+src
src/wiq_pkg.sv
src/wiq_ram.sv
src/wiq_lane.sv
src/wiq_merge.sv
src/wiq_scalar.sv
src/weighted_ik_qp_setup.sv
src/wiq_checker.sv
tb/sv/wiq_checker.sv
tb/sv/tb.sv
